// File: design/ttrr_pkg.sv
// Shared types and constants for the thread table with round-robin scheduling.
`timescale 1ns / 1ps

package ttrr_pkg;

   // Default table sizes.
   localparam int THREAD_SLOTS_DEFAULT  = 16;
   localparam int PROCESS_SLOTS_DEFAULT = 16;

   // Field widths of the call and result transactions.
   localparam int ACTION_W = 3;
   localparam int ADDR_W   = 32;
   localparam int STATUS_W = 2;
   localparam int INDEX_W  = 4;

   // Word returned by the version call.
   localparam logic [ADDR_W-1:0] VERSION_WORD = 32'h0001_0000;

   // Call codes; the remaining codes are illegal.
   typedef enum logic [ACTION_W-1:0] {
      ACT_VERSION     = 3'd0,
      ACT_CREATE_PROC = 3'd1,
      ACT_CREATE_THR  = 3'd2,
      ACT_TERMINATE   = 3'd3,
      ACT_YIELD       = 3'd4
   } action_type;

   // Result status codes.
   typedef enum logic [STATUS_W-1:0] {
      ST_OK      = 2'd0,
      ST_NO_SLOT = 2'd1,
      ST_HALTED  = 2'd2,
      ST_ILLEGAL = 2'd3
   } status_type;

   // Sequencer states.
   typedef enum logic [1:0] {
      SQ_IDLE = 2'd0,
      SQ_READ = 2'd1,
      SQ_EXEC = 2'd2,
      SQ_RESP = 2'd3
   } state_type;

endpackage

// File: design/ttrr_if.sv
// Call and result channel interfaces with valid/ready handshakes.
`timescale 1ns / 1ps

interface ttrr_req_if;
   import ttrr_pkg::*;

   logic                valid;
   logic                ready;
   logic [ACTION_W-1:0] action;
   logic [ADDR_W-1:0]   entry_address;
   logic [ADDR_W-1:0]   stack_address;

   modport source (output valid, output action, output entry_address,
                   output stack_address, input ready);
   modport sink   (input valid, input action, input entry_address,
                   input stack_address, output ready);
endinterface

interface ttrr_rsp_if;
   import ttrr_pkg::*;

   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [ADDR_W-1:0]   result_value;
   logic [INDEX_W-1:0]  running_thread;
   logic [ADDR_W-1:0]   running_pc;
   logic [ADDR_W-1:0]   running_stack;
   logic [INDEX_W-1:0]  running_process;

   modport source (output valid, output status, output result_value,
                   output running_thread, output running_pc, output running_stack,
                   output running_process, input ready);
   modport sink   (input valid, input status, input result_value,
                   input running_thread, input running_pc, input running_stack,
                   input running_process, output ready);
endinterface

// File: design/ttrr_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps

module ttrr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read; a read of the address being written sees old data.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: design/ttrr_find_first.sv
// Priority encoder that returns the lowest set bit of a vector.
`timescale 1ns / 1ps

module ttrr_find_first #(
   parameter int W = 16,
   localparam int IW = (W > 1) ? $clog2(W) : 1
) (
   input  logic [W-1:0]  vec,
   output logic          found,
   output logic [IW-1:0] index
);

   // Scan from the top so that the lowest set bit wins.
   always_comb begin
      found = |vec;
      index = '0;
      for (int i = W - 1; i >= 0; i--) begin
         if (vec[i]) begin
            index = IW'(i);
         end
      end
   end

endmodule

// File: design/thread_table_round_robin.sv
// Top level: thread and process tables in RAM, sequenced call handling, round-robin yield.
// A call is taken in the idle state and then passes the read, execute and response states; it
// waits in the response state while the result channel stalls, and no new call is taken until
// its result is loaded. The thread RAM read port serves the current thread, the free slot and
// the new current thread in turn. Reset is synchronous and clears the live, process and
// stack-written flags, so no clearing pass is needed; a call can be taken once reset ends.
`timescale 1ns / 1ps

module thread_table_round_robin #(
   parameter int THREAD_SLOTS  = ttrr_pkg::THREAD_SLOTS_DEFAULT,
   parameter int PROCESS_SLOTS = ttrr_pkg::PROCESS_SLOTS_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   ttrr_req_if.sink   req_if,
   ttrr_rsp_if.source rsp_if
);
   import ttrr_pkg::*;

   localparam int TW  = $clog2(THREAD_SLOTS);
   localparam int PW  = (PROCESS_SLOTS > 1) ? $clog2(PROCESS_SLOTS) : 1;
   localparam int CW  = $clog2(THREAD_SLOTS + 1);
   localparam int TDW = PW + 2 * ADDR_W;

   // Control registers.
   state_type               state_ff, state_in;
   logic [TW-1:0]           cur_ff, cur_in;
   logic                    halted_ff, halted_in;
   logic [THREAD_SLOTS-1:0] live_ff, live_in;
   logic [THREAD_SLOTS-1:0] stack_set_ff, stack_set_in;
   logic [PROCESS_SLOTS-1:0] plive_ff, plive_in;
   logic                    rsp_valid_ff, rsp_valid_in;

   // Payload registers of the call in progress.
   action_type              action_ff;
   logic [ADDR_W-1:0]       entry_ff, stack_ff;
   logic [TW-1:0]           tslot_ff;
   logic                    tfound_ff;
   logic [PW-1:0]           pslot_ff;
   logic                    pfound_ff;
   logic [PW-1:0]           owner_ff;
   status_type              status_ff, status_in;
   logic [ADDR_W-1:0]       value_ff, value_in;
   logic                    fwd_ff, fwd_in;
   logic [TDW-1:0]          fwd_word_ff;

   // Result registers.
   status_type              rsp_status_ff;
   logic [ADDR_W-1:0]       rsp_value_ff, rsp_pc_ff, rsp_stack_ff;
   logic [INDEX_W-1:0]      rsp_thread_ff, rsp_process_ff;
   logic                    rsp_load;

   // RAM ports.
   logic                    t_we;
   logic [TW-1:0]           t_waddr, t_raddr;
   logic [TDW-1:0]          t_wdata, t_rdata;
   logic                    c_we;
   logic [PW-1:0]           c_waddr, c_raddr;
   logic [CW-1:0]           c_wdata, c_rdata;

   // Search results.
   logic                    tfree_found, pfree_found, above_found, any_found;
   logic [TW-1:0]           tfree_idx, above_idx, any_idx;
   logic [PW-1:0]           pfree_idx;
   logic [THREAD_SLOTS-1:0] yield_vec, above_vec;

   // Helper values for the execute step.
   logic                    cur_live;
   logic                    term_ok;
   logic [CW-1:0]           cnt_dec;
   logic [ADDR_W-1:0]       stack_keep;
   logic [TW+INDEX_W-1:0]   cur_wide;
   logic [PW+INDEX_W-1:0]   owner_wide;
   logic [TDW-1:0]          cur_word;

   // Thread record RAM: owner, saved pc and saved stack pointer.
   ttrr_ram #(.WIDTH(TDW), .DEPTH(THREAD_SLOTS)) u_thread_ram (
      .clock   (clock),
      .wr_en   (t_we),
      .wr_addr (t_waddr),
      .wr_data (t_wdata),
      .rd_addr (t_raddr),
      .rd_data (t_rdata)
   );

   // Process thread count RAM.
   ttrr_ram #(.WIDTH(CW), .DEPTH(PROCESS_SLOTS)) u_count_ram (
      .clock   (clock),
      .wr_en   (c_we),
      .wr_addr (c_waddr),
      .wr_data (c_wdata),
      .rd_addr (c_raddr),
      .rd_data (c_rdata)
   );

   // Free slot searches over the live flags.
   ttrr_find_first #(.W(THREAD_SLOTS)) u_free_thread (
      .vec   (~live_ff),
      .found (tfree_found),
      .index (tfree_idx)
   );

   ttrr_find_first #(.W(PROCESS_SLOTS)) u_free_process (
      .vec   (~plive_ff),
      .found (pfree_found),
      .index (pfree_idx)
   );

   // Round-robin search: first live thread above the current one, else the lowest live one.
   assign term_ok = (action_ff == ACT_TERMINATE) && cur_live;

   always_comb begin
      for (int i = 0; i < THREAD_SLOTS; i++) begin
         yield_vec[i] = live_ff[i] && !(term_ok && (cur_ff == TW'(i)));
         above_vec[i] = yield_vec[i] && (TW'(i) > cur_ff);
      end
   end

   ttrr_find_first #(.W(THREAD_SLOTS)) u_next_above (
      .vec   (above_vec),
      .found (above_found),
      .index (above_idx)
   );

   ttrr_find_first #(.W(THREAD_SLOTS)) u_next_any (
      .vec   (yield_vec),
      .found (any_found),
      .index (any_idx)
   );

   assign cur_live   = live_ff[cur_ff];
   assign cnt_dec    = (c_rdata != '0) ? c_rdata - CW'(1) : c_rdata;
   assign stack_keep = stack_set_ff[tslot_ff] ? t_rdata[ADDR_W-1:0] : '0;
   assign cur_word   = fwd_ff ? fwd_word_ff : t_rdata;
   assign cur_wide   = {{INDEX_W{1'b0}}, cur_ff};
   assign owner_wide = {{INDEX_W{1'b0}}, cur_word[TDW-1:2*ADDR_W]};
   assign rsp_load   = (state_ff == SQ_RESP) && (!rsp_valid_ff || rsp_if.ready);

   // Sequencer: next state, table updates and RAM controls.
   always_comb begin
      state_in     = state_ff;
      cur_in       = cur_ff;
      halted_in    = halted_ff;
      live_in      = live_ff;
      stack_set_in = stack_set_ff;
      plive_in     = plive_ff;
      status_in    = status_ff;
      value_in     = value_ff;
      fwd_in       = fwd_ff;
      t_we         = 1'b0;
      t_waddr      = tslot_ff;
      t_wdata      = {owner_ff, entry_ff, stack_ff};
      t_raddr      = cur_ff;
      c_we         = 1'b0;
      c_waddr      = owner_ff;
      c_wdata      = c_rdata + CW'(1);
      c_raddr      = owner_ff;

      unique case (state_ff)
         SQ_IDLE: begin
            // Read the current thread's record while the call is taken.
            if (req_if.valid) begin
               state_in = SQ_READ;
            end
         end
         SQ_READ: begin
            // Fetch the free slot's record and the owner's thread count.
            t_raddr  = tfree_idx;
            c_raddr  = t_rdata[TDW-1:2*ADDR_W];
            state_in = SQ_EXEC;
         end
         SQ_EXEC: begin
            status_in = ST_OK;
            value_in  = '0;
            if (halted_ff) begin
               status_in = ST_HALTED;
            end else begin
               unique case (action_ff)
                  ACT_VERSION: begin
                     value_in = VERSION_WORD;
                  end
                  ACT_CREATE_PROC: begin
                     if (!pfound_ff || !tfound_ff) begin
                        status_in = ST_NO_SLOT;
                     end else begin
                        plive_in[pslot_ff]     = 1'b1;
                        live_in[tslot_ff]      = 1'b1;
                        stack_set_in[tslot_ff] = 1'b1;
                        t_we    = 1'b1;
                        t_wdata = {pslot_ff, entry_ff, stack_keep};
                        c_we    = 1'b1;
                        c_waddr = pslot_ff;
                        c_wdata = CW'(1);
                     end
                  end
                  ACT_CREATE_THR: begin
                     if (!cur_live || !tfound_ff) begin
                        status_in = ST_NO_SLOT;
                     end else begin
                        live_in[tslot_ff]      = 1'b1;
                        stack_set_in[tslot_ff] = 1'b1;
                        t_we = 1'b1;
                        c_we = 1'b1;
                     end
                  end
                  ACT_TERMINATE: begin
                     if (!cur_live) begin
                        status_in = ST_NO_SLOT;
                     end else begin
                        live_in[cur_ff] = 1'b0;
                        c_we    = 1'b1;
                        c_wdata = cnt_dec;
                        if (cnt_dec == '0) begin
                           plive_in[owner_ff] = 1'b0;
                        end
                        if (above_found) begin
                           cur_in = above_idx;
                        end else if (any_found) begin
                           cur_in = any_idx;
                        end else begin
                           halted_in = 1'b1;
                           status_in = ST_HALTED;
                        end
                     end
                  end
                  ACT_YIELD: begin
                     if (above_found) begin
                        cur_in = above_idx;
                     end else if (any_found) begin
                        cur_in = any_idx;
                     end else begin
                        halted_in = 1'b1;
                        status_in = ST_HALTED;
                     end
                  end
                  default: begin
                     status_in = ST_ILLEGAL;
                  end
               endcase
            end
            // Read the new current thread; forward the record if it is being written now.
            t_raddr  = cur_in;
            fwd_in   = t_we && (t_waddr == cur_in);
            state_in = SQ_RESP;
         end
         SQ_RESP: begin
            if (rsp_load) begin
               state_in = SQ_IDLE;
            end
         end
         default: begin
            state_in = SQ_IDLE;
         end
      endcase
   end

   // Result channel valid flag.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end
   end

   // Control state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= SQ_IDLE;
         cur_ff       <= '0;
         halted_ff    <= 1'b0;
         live_ff      <= '0;
         stack_set_ff <= '0;
         plive_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cur_ff       <= cur_in;
         halted_ff    <= halted_in;
         live_ff      <= live_in;
         stack_set_ff <= stack_set_in;
         plive_ff     <= plive_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers of the call in progress.
   always_ff @(posedge clock) begin
      if (state_ff == SQ_IDLE && req_if.valid) begin
         action_ff <= action_type'(req_if.action);
         entry_ff  <= req_if.entry_address;
         stack_ff  <= req_if.stack_address;
      end
      if (state_ff == SQ_READ) begin
         tslot_ff  <= tfree_idx;
         tfound_ff <= tfree_found;
         pslot_ff  <= pfree_idx;
         pfound_ff <= pfree_found;
         owner_ff  <= t_rdata[TDW-1:2*ADDR_W];
      end
      if (state_ff == SQ_EXEC) begin
         fwd_word_ff <= t_wdata;
      end
      status_ff <= status_in;
      value_ff  <= value_in;
      fwd_ff    <= fwd_in;
   end

   // Result registers; a thread that is not live reports zero pc, stack and process fields.
   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_status_ff <= status_ff;
         rsp_value_ff  <= value_ff;
         rsp_thread_ff <= cur_wide[INDEX_W-1:0];
         if (cur_live) begin
            rsp_pc_ff      <= cur_word[2*ADDR_W-1:ADDR_W];
            rsp_stack_ff   <= cur_word[ADDR_W-1:0];
            rsp_process_ff <= owner_wide[INDEX_W-1:0];
         end else begin
            rsp_pc_ff      <= '0;
            rsp_stack_ff   <= '0;
            rsp_process_ff <= '0;
         end
      end
   end

   // Channel outputs.
   assign req_if.ready           = (state_ff == SQ_IDLE);
   assign rsp_if.valid           = rsp_valid_ff;
   assign rsp_if.status          = rsp_status_ff;
   assign rsp_if.result_value    = rsp_value_ff;
   assign rsp_if.running_thread  = rsp_thread_ff;
   assign rsp_if.running_pc      = rsp_pc_ff;
   assign rsp_if.running_stack   = rsp_stack_ff;
   assign rsp_if.running_process = rsp_process_ff;

endmodule
